FILE: sv/prv_pkg.sv
`timescale 1ns / 1ps
package prv_pkg;

    localparam int DELAY_WORDS_DEF = 32768;
    localparam int SAMPLE_RATE_DEF = 48000;
    localparam int REF_RATE_HZ     = 48000;
    localparam int SAMPLE_BITS     = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_W           = 16;

    // line lengths and taps at the reference rate
    localparam int unsigned LEN_AP1 = 150;
    localparam int unsigned LEN_AP2 = 214;
    localparam int unsigned LEN_AP3 = 319;
    localparam int unsigned LEN_AP4 = 527;
    localparam int unsigned LEN_T1A = 2182;
    localparam int unsigned LEN_T1B = 2690;
    localparam int unsigned LEN_D1  = 4501;
    localparam int unsigned LEN_T2A = 2525;
    localparam int unsigned LEN_T2B = 2197;
    localparam longint unsigned TAP1_SMP = 4460;
    localparam longint unsigned TAP2_SMP = 6261;
    localparam longint unsigned AMP1_SMP = 40;
    localparam longint unsigned AMP2_SMP = 50;

    // quarter-wave sine polynomial
    localparam longint COS_C0 = 85569278;
    localparam longint COS_K1 = 5026937;
    localparam longint COS_C1 = 693598563;
    localparam longint COS_C2 = 1686629713;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYPASS = 3'd0,
        REG_WET    = 3'd1,
        REG_DECAY  = 3'd2,
        REG_DAMP   = 3'd3,
        REG_DIFF   = 3'd4,
        REG_SMOOTH = 3'd5,
        REG_LFO1   = 3'd6,
        REG_LFO2   = 3'd7
    } cfg_reg_t;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE,
        ST_LF_P, ST_LF_T, ST_LF_M1, ST_LF_M2, ST_LF_M3, ST_LF_M4, ST_LF_M5,
        ST_LF_M6, ST_LF_M7, ST_LF_M8, ST_LF_M9,
        ST_AP_RA, ST_AP_M1, ST_AP_W, ST_AP_M2, ST_AP_Y,
        ST_IN_M, ST_IN_P, ST_IN_RA, ST_IN_RB, ST_IN_D, ST_IN_S,
        ST_TK_M1, ST_TK_A, ST_TK_M2, ST_TK_L, ST_TK_WR,
        ST_SM_M, ST_SM_A, ST_OUT_M, ST_OUT_A, ST_DONE
    } state_t;

    function automatic sample_t sat_s(input logic signed [51:0] v);
        logic signed [51:0] smax;
        logic signed [51:0] smin;
        smax = (52'sd1 <<< (SAMPLE_BITS - 1)) - 52'sd1;
        smin = -smax - 52'sd1;
        if (v > smax) begin
            return sample_t'(smax);
        end
        if (v < smin) begin
            return sample_t'(smin);
        end
        return sample_t'(v);
    endfunction

endpackage

FILE: sv/prv_ram.sv
`timescale 1ns / 1ps
module prv_ram #(
    parameter int DEPTH = prv_pkg::DELAY_WORDS_DEF,
    parameter int AW    = $clog2(prv_pkg::DELAY_WORDS_DEF)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  prv_pkg::sample_t wdata,
    input  logic [AW-1:0]    raddr,
    output prv_pkg::sample_t rdata
);
    import prv_pkg::*;

    sample_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/plate_reverb_stereo_unit.sv
`timescale 1ns / 1ps
// Stereo plate reverb: one stereo pair in, one wet pair out per transaction.
// Input diffusion (four allpasses) feeds a figure-eight tank of two
// cross-coupled paths, each with an LFO-modulated interpolated delay read,
// decay gain, damping lowpass and two allpasses; all lines share one
// single-port-write / single-port-read delay RAM of DELAY_WORDS samples.
// Every step goes through one shared 33x18 multiplier and the RAM ports
// under a sequencer; on every 32nd pair the two LFOs are refreshed
// first (the cosine polynomial is five multiplies per LFO). Bypass pairs
// return zeros and touch no state. After reset the block runs a clearing
// pass over every word of the RAM with in_stall high;
// configuration writes are taken at any time but are meant for idle periods.
// in_stall is high while a pair is in work; a finished result waits in the
// output register while the next pair may be accepted.
module plate_reverb_stereo_unit #(
    parameter int DELAY_WORDS    = prv_pkg::DELAY_WORDS_DEF,
    parameter int SAMPLE_RATE_HZ = prv_pkg::SAMPLE_RATE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  prv_pkg::sample_t              left_in,
    input  prv_pkg::sample_t              right_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output prv_pkg::sample_t              left_out,
    output prv_pkg::sample_t              right_out,
    input  logic                          cfg_we,
    input  logic [prv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prv_pkg::CFG_W-1:0]     cfg_data
);
    import prv_pkg::*;

    localparam int AW = $clog2(DELAY_WORDS);
    localparam int SW = ((AW > 16) ? AW : 16) + 2;

    // line lengths scaled to the sample rate
    localparam int unsigned L_AP1 = (LEN_AP1 * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_AP2 = (LEN_AP2 * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_AP3 = (LEN_AP3 * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_AP4 = (LEN_AP4 * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_T1A = (LEN_T1A * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_T1B = (LEN_T1B * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_D1  = (LEN_D1 * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_T2A = (LEN_T2A * SAMPLE_RATE_HZ) / REF_RATE_HZ;
    localparam int unsigned L_T2B = (LEN_T2B * SAMPLE_RATE_HZ) / REF_RATE_HZ;

    // memory layout
    localparam int unsigned B_AP1 = 0;
    localparam int unsigned B_AP2 = B_AP1 + L_AP1 + 1;
    localparam int unsigned B_AP3 = B_AP2 + L_AP2 + 1;
    localparam int unsigned B_AP4 = B_AP3 + L_AP3 + 1;
    localparam int unsigned B_T1A = B_AP4 + L_AP4 + 1;
    localparam int unsigned B_T1B = B_T1A + L_T1A + 1;
    localparam int unsigned B_D1  = B_T1B + L_T1B + 1;
    localparam int unsigned B_T2A = B_D1 + L_D1 + 1;
    localparam int unsigned B_T2B = B_T2A + L_T2A + 1;
    localparam int unsigned B_D2  = B_T2B + L_T2B + 1;

    // offsets folded into the memory once, at elaboration
    localparam logic [AW-1:0] H_AP1 = AW'(B_AP1 % DELAY_WORDS);
    localparam logic [AW-1:0] H_AP2 = AW'(B_AP2 % DELAY_WORDS);
    localparam logic [AW-1:0] H_AP3 = AW'(B_AP3 % DELAY_WORDS);
    localparam logic [AW-1:0] H_AP4 = AW'(B_AP4 % DELAY_WORDS);
    localparam logic [AW-1:0] H_T1A = AW'(B_T1A % DELAY_WORDS);
    localparam logic [AW-1:0] H_T1B = AW'(B_T1B % DELAY_WORDS);
    localparam logic [AW-1:0] H_T2A = AW'(B_T2A % DELAY_WORDS);
    localparam logic [AW-1:0] H_T2B = AW'(B_T2B % DELAY_WORDS);
    localparam logic [AW-1:0] H_D1  = AW'(B_D1 % DELAY_WORDS);
    localparam logic [AW-1:0] H_D2  = AW'(B_D2 % DELAY_WORDS);
    localparam logic [AW-1:0] T_AP1 = AW'((B_AP1 + L_AP1 - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_AP2 = AW'((B_AP2 + L_AP2 - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_AP3 = AW'((B_AP3 + L_AP3 - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_AP4 = AW'((B_AP4 + L_AP4 - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_T1A = AW'((B_T1A + L_T1A - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_T1B = AW'((B_T1B + L_T1B - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_T2A = AW'((B_T2A + L_T2A - 1) % DELAY_WORDS);
    localparam logic [AW-1:0] T_T2B = AW'((B_T2B + L_T2B - 1) % DELAY_WORDS);

    // modulated taps, Q.16 samples
    localparam logic signed [32:0] TAP1_Q =
        33'((TAP1_SMP * 65536 * SAMPLE_RATE_HZ) / REF_RATE_HZ);
    localparam logic signed [32:0] TAP2_Q =
        33'((TAP2_SMP * 65536 * SAMPLE_RATE_HZ) / REF_RATE_HZ);
    localparam logic signed [32:0] AMP1_Q =
        33'((AMP1_SMP * 65536 * SAMPLE_RATE_HZ) / REF_RATE_HZ);
    localparam logic signed [32:0] AMP2_Q =
        33'((AMP2_SMP * 65536 * SAMPLE_RATE_HZ) / REF_RATE_HZ);

    localparam logic [AW-1:0] WP_LAST = AW'(DELAY_WORDS - 1);

    function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] s);
        logic [SW-1:0] v;
        v = s;
        for (int i = 0; i < 3; i++) begin
            if (v >= SW'(DELAY_WORDS)) begin
                v = v - SW'(DELAY_WORDS);
            end
        end
        return v[AW-1:0];
    endfunction

    // ---- registers ----
    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] wp_reg, wp_next;

    logic        bypass_reg;
    logic [15:0] wet_reg, decay_reg, damp_reg, diff_reg, smooth_reg, rate1_reg, rate2_reg;

    logic [23:0] ph1_reg, ph1_next, ph2_reg, ph2_next;
    sample_t     lfo1_reg, lfo1_next, lfo2_reg, lfo2_next;
    logic signed [19:0] lpl_reg, lpl_next, lpr_reg, lpr_next;
    logic [23:0] sm_reg, sm_next;

    sample_t x_reg, x_next, tail_reg, tail_next, dif_reg, dif_next, a_reg, a_next;
    logic signed [16:0] fb_reg, fb_next;
    logic signed [32:0] pos_reg, pos_next;
    logic [16:0] tt_reg, tt_next, t2_reg, t2_next;
    logic signed [31:0] p_reg, p_next;
    logic neg_reg, neg_next, lfo_idx_reg, lfo_idx_next, side_reg, side_next;
    logic [2:0] ap_idx_reg, ap_idx_next;
    sample_t lres_reg, lres_next, rres_reg, rres_next;
    sample_t outl_reg, outl_next, outr_reg, outr_next;
    logic    outv_reg, outv_next;
    logic signed [50:0] prod_reg;

    // ---- shared multiplier and RAM ports ----
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    sample_t       ram_wdata, ram_rdata;

    assign mul_p = mul_a * mul_b;

    prv_ram #(.DEPTH(DELAY_WORDS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- helpers ----
    logic          in_acc;
    logic [AW-1:0] wp_dec;
    logic [AW-1:0] ap_head, ap_tail;
    logic          ap_neg;
    logic signed [17:0] k_cur;
    logic signed [50:0] prod_s16;
    logic [23:0]   ph_cur;
    logic signed [19:0] lp_cur, lp_new;
    logic signed [50:0] cos_raw;
    sample_t       cos_mag;
    logic [15:0]   ip;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = outv_reg;
    assign left_out  = outl_reg;
    assign right_out = outr_reg;
    assign wp_dec    = (wp_reg == '0) ? WP_LAST : wp_reg - AW'(1);
    assign prod_s16  = prod_reg >>> 16;
    assign ph_cur    = lfo_idx_reg ? ph2_reg : ph1_reg;
    assign lp_cur    = side_reg ? lpr_reg : lpl_reg;
    assign lp_new    = 20'(52'(lp_cur) + 52'(prod_s16));
    assign cos_raw   = prod_reg >>> 31;
    assign cos_mag   = (cos_raw > 51'sd32767) ? 16'sd32767 : sample_t'(cos_raw);
    assign ip        = pos_reg[31:16];

    always_comb
    begin
        case (ap_idx_reg)
            3'd0:    begin ap_head = H_AP1; ap_tail = T_AP1; end
            3'd1:    begin ap_head = H_AP2; ap_tail = T_AP2; end
            3'd2:    begin ap_head = H_AP3; ap_tail = T_AP3; end
            3'd3:    begin ap_head = H_AP4; ap_tail = T_AP4; end
            3'd4:    begin ap_head = H_T1A; ap_tail = T_T1A; end
            3'd5:    begin ap_head = H_T1B; ap_tail = T_T1B; end
            3'd6:    begin ap_head = H_T2A; ap_tail = T_T2A; end
            default: begin ap_head = H_T2B; ap_tail = T_T2B; end
        endcase
    end

    // first tank allpass of the left path and second of the right path invert
    assign ap_neg = (ap_idx_reg == 3'd4) || (ap_idx_reg == 3'd7);
    assign k_cur  = ap_neg ? -$signed({2'b00, diff_reg}) : $signed({2'b00, diff_reg});

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == WP_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (bypass_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (wp_dec[4:0] == 5'd0)
                    begin
                        state_next = ST_LF_P;
                    end
                    else
                    begin
                        state_next = ST_AP_RA;
                    end
                end
            end
            ST_LF_P:  state_next = ST_LF_T;
            ST_LF_T:  state_next = ST_LF_M1;
            ST_LF_M1: state_next = ST_LF_M2;
            ST_LF_M2: state_next = ST_LF_M3;
            ST_LF_M3: state_next = ST_LF_M4;
            ST_LF_M4: state_next = ST_LF_M5;
            ST_LF_M5: state_next = ST_LF_M6;
            ST_LF_M6: state_next = ST_LF_M7;
            ST_LF_M7: state_next = ST_LF_M8;
            ST_LF_M8: state_next = ST_LF_M9;
            ST_LF_M9: state_next = lfo_idx_reg ? ST_AP_RA : ST_LF_P;
            ST_AP_RA: state_next = ST_AP_M1;
            ST_AP_M1: state_next = ST_AP_W;
            ST_AP_W:  state_next = ST_AP_M2;
            ST_AP_M2: state_next = ST_AP_Y;
            ST_AP_Y:
            begin
                case (ap_idx_reg)
                    3'd3:          state_next = ST_IN_M;
                    3'd5, 3'd7:    state_next = ST_TK_WR;
                    default:       state_next = ST_AP_RA;
                endcase
            end
            ST_IN_M:  state_next = ST_IN_P;
            ST_IN_P:  state_next = ST_IN_RA;
            ST_IN_RA: state_next = ST_IN_RB;
            ST_IN_RB: state_next = ST_IN_D;
            ST_IN_D:  state_next = ST_IN_S;
            ST_IN_S:  state_next = ST_TK_M1;
            ST_TK_M1: state_next = ST_TK_A;
            ST_TK_A:  state_next = ST_TK_M2;
            ST_TK_M2: state_next = ST_TK_L;
            ST_TK_L:  state_next = ST_AP_RA;
            ST_TK_WR: state_next = side_reg ? ST_OUT_M : ST_SM_M;
            ST_SM_M:  state_next = ST_SM_A;
            ST_SM_A:  state_next = ST_OUT_M;
            ST_OUT_M: state_next = ST_OUT_A;
            ST_OUT_A: state_next = side_reg ? ST_DONE : ST_IN_M;
            ST_DONE:
            begin
                if (!outv_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---- datapath control and next values ----
    always_comb
    begin
        clr_next     = clr_reg;
        wp_next      = wp_reg;
        ph1_next     = ph1_reg;
        ph2_next     = ph2_reg;
        lfo1_next    = lfo1_reg;
        lfo2_next    = lfo2_reg;
        lpl_next     = lpl_reg;
        lpr_next     = lpr_reg;
        sm_next      = sm_reg;
        x_next       = x_reg;
        tail_next    = tail_reg;
        dif_next     = dif_reg;
        a_next       = a_reg;
        fb_next      = fb_reg;
        pos_next     = pos_reg;
        tt_next      = tt_reg;
        t2_next      = t2_reg;
        p_next       = p_reg;
        neg_next     = neg_reg;
        lfo_idx_next = lfo_idx_reg;
        side_next    = side_reg;
        ap_idx_next  = ap_idx_reg;
        lres_next    = lres_reg;
        rres_next    = rres_reg;
        outl_next    = outl_reg;
        outr_next    = outr_reg;
        outv_next    = outv_reg && out_stall;
        mul_a        = '0;
        mul_b        = '0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    lfo_idx_next = 1'b0;
                    ap_idx_next  = 3'd0;
                    side_next    = 1'b0;
                    lres_next    = '0;
                    rres_next    = '0;
                    if (!bypass_reg)
                    begin
                        wp_next = wp_dec;
                        x_next  = sample_t'((17'(left_in) + 17'(right_in)) >>> 1);
                    end
                end
            end
            ST_LF_P:
            begin
                if (lfo_idx_reg)
                begin
                    ph2_next = ph2_reg + {8'd0, rate2_reg};
                end
                else
                begin
                    ph1_next = ph1_reg + {8'd0, rate1_reg};
                end
            end
            ST_LF_T:
            begin
                // quadrants 0 and 2 use the mirrored fraction, 1 and 2 negate
                tt_next  = ph_cur[22] ? {1'b0, ph_cur[21:6]}
                                      : 17'd65536 - {1'b0, ph_cur[21:6]};
                neg_next = ph_cur[23] ^ ph_cur[22];
            end
            ST_LF_M1:
            begin
                mul_a = $signed({16'd0, tt_reg});
                mul_b = $signed({1'b0, tt_reg});
            end
            ST_LF_M2:
            begin
                t2_next = prod_reg[32:16];
                mul_a   = 33'(COS_K1);
                mul_b   = $signed({1'b0, prod_reg[32:16]});
            end
            ST_LF_M3: p_next = 32'(52'(COS_C0) - 52'(prod_s16));
            ST_LF_M4:
            begin
                mul_a = 33'(p_reg);
                mul_b = $signed({1'b0, t2_reg});
            end
            ST_LF_M5: p_next = 32'(52'(COS_C1) - 52'(prod_s16));
            ST_LF_M6:
            begin
                mul_a = 33'(p_reg);
                mul_b = $signed({1'b0, t2_reg});
            end
            ST_LF_M7: p_next = 32'(52'(COS_C2) - 52'(prod_s16));
            ST_LF_M8:
            begin
                mul_a = 33'(p_reg);
                mul_b = $signed({1'b0, tt_reg});
            end
            ST_LF_M9:
            begin
                if (lfo_idx_reg)
                begin
                    lfo2_next = neg_reg ? -cos_mag : cos_mag;
                end
                else
                begin
                    lfo1_next = neg_reg ? -cos_mag : cos_mag;
                end
                lfo_idx_next = 1'b1;
            end
            ST_AP_RA:
            begin
                ram_raddr = wrap_addr(SW'(wp_reg) + SW'(ap_tail));
            end
            ST_AP_M1:
            begin
                tail_next = ram_rdata;
                mul_a     = 33'(ram_rdata);
                mul_b     = k_cur;
            end
            ST_AP_W:
            begin
                x_next    = sat_s(52'(x_reg) + 52'(prod_s16));
                ram_we    = 1'b1;
                ram_waddr = wrap_addr(SW'(wp_reg) + SW'(ap_head));
                ram_wdata = sat_s(52'(x_reg) + 52'(prod_s16));
            end
            ST_AP_M2:
            begin
                mul_a = 33'(x_reg);
                mul_b = k_cur;
            end
            ST_AP_Y:
            begin
                x_next = sat_s(52'(tail_reg) - 52'(prod_s16));
                if (ap_idx_reg == 3'd3)
                begin
                    dif_next = sat_s(52'(tail_reg) - 52'(prod_s16));
                end
                ap_idx_next = ap_idx_reg + 3'd1;
            end
            ST_IN_M:
            begin
                mul_a = side_reg ? AMP1_Q : AMP2_Q;
                mul_b = 18'(side_reg ? lfo1_reg : lfo2_reg);
            end
            ST_IN_P:
            begin
                pos_next = 33'(52'(side_reg ? TAP1_Q : TAP2_Q) + 52'(prod_reg >>> 15));
            end
            ST_IN_RA:
            begin
                ram_raddr = wrap_addr(SW'(wp_reg) + SW'(side_reg ? H_D1 : H_D2) + SW'(ip));
            end
            ST_IN_RB:
            begin
                a_next    = ram_rdata;
                ram_raddr = wrap_addr(SW'(wp_reg) + SW'(side_reg ? H_D1 : H_D2)
                                      + SW'(ip) + SW'(1));
            end
            ST_IN_D:
            begin
                mul_a = 33'(ram_rdata) - 33'(a_reg);
                mul_b = $signed({2'b00, pos_reg[15:0]});
            end
            ST_IN_S: fb_next = 17'(52'(a_reg) + 52'(prod_s16));
            ST_TK_M1:
            begin
                mul_a = 33'(fb_reg);
                mul_b = $signed({2'b00, decay_reg});
            end
            ST_TK_A: x_next = sat_s(52'(dif_reg) + 52'(prod_s16));
            ST_TK_M2:
            begin
                mul_a = 33'($signed({x_reg, 4'd0})) - 33'(lp_cur);
                mul_b = $signed({2'b00, damp_reg});
            end
            ST_TK_L:
            begin
                if (side_reg)
                begin
                    lpr_next = lp_new;
                end
                else
                begin
                    lpl_next = lp_new;
                end
                x_next      = sample_t'(lp_new >>> 4);
                ap_idx_next = side_reg ? 3'd6 : 3'd4;
            end
            ST_TK_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wrap_addr(SW'(wp_reg) + SW'(side_reg ? H_D2 : H_D1));
                ram_wdata = x_reg;
            end
            ST_SM_M:
            begin
                mul_a = 33'($signed({2'b00, wet_reg, 8'd0}) - $signed({2'b00, sm_reg}));
                mul_b = $signed({2'b00, smooth_reg});
            end
            ST_SM_A: sm_next = 24'(52'($signed({1'b0, sm_reg})) + 52'(prod_s16));
            ST_OUT_M:
            begin
                mul_a = $signed({9'd0, sm_reg});
                mul_b = 18'(x_reg);
            end
            ST_OUT_A:
            begin
                if (side_reg)
                begin
                    rres_next = sat_s(52'(prod_reg >>> 23));
                end
                else
                begin
                    lres_next = sat_s(52'(prod_reg >>> 23));
                end
                side_next = 1'b1;
            end
            ST_DONE:
            begin
                if (!outv_reg || !out_stall)
                begin
                    outl_next = lres_reg;
                    outr_next = rres_reg;
                    outv_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wp_reg      <= '0;
            ph1_reg     <= '0;
            ph2_reg     <= '0;
            lfo1_reg    <= '0;
            lfo2_reg    <= '0;
            lpl_reg     <= '0;
            lpr_reg     <= '0;
            sm_reg      <= '0;
            lfo_idx_reg <= 1'b0;
            side_reg    <= 1'b0;
            ap_idx_reg  <= '0;
            outv_reg    <= 1'b0;
            bypass_reg  <= 1'b0;
            wet_reg     <= 16'd0;
            decay_reg   <= 16'd32768;
            damp_reg    <= 16'd45875;
            diff_reg    <= 16'd40960;
            smooth_reg  <= 16'd66;
            rate1_reg   <= 16'd5592;
            rate2_reg   <= 16'd3355;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wp_reg      <= wp_next;
            ph1_reg     <= ph1_next;
            ph2_reg     <= ph2_next;
            lfo1_reg    <= lfo1_next;
            lfo2_reg    <= lfo2_next;
            lpl_reg     <= lpl_next;
            lpr_reg     <= lpr_next;
            sm_reg      <= sm_next;
            lfo_idx_reg <= lfo_idx_next;
            side_reg    <= side_next;
            ap_idx_reg  <= ap_idx_next;
            outv_reg    <= outv_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BYPASS: bypass_reg <= cfg_data[0];
                    REG_WET:    wet_reg    <= cfg_data;
                    REG_DECAY:  decay_reg  <= cfg_data;
                    REG_DAMP:   damp_reg   <= cfg_data;
                    REG_DIFF:   diff_reg   <= cfg_data;
                    REG_SMOOTH: smooth_reg <= cfg_data;
                    REG_LFO1:   rate1_reg  <= cfg_data;
                    REG_LFO2:   rate2_reg  <= cfg_data;
                    default:    bypass_reg <= bypass_reg;
                endcase
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        x_reg    <= x_next;
        tail_reg <= tail_next;
        dif_reg  <= dif_next;
        a_reg    <= a_next;
        fb_reg   <= fb_next;
        pos_reg  <= pos_next;
        tt_reg   <= tt_next;
        t2_reg   <= t2_next;
        p_reg    <= p_next;
        neg_reg  <= neg_next;
        lres_reg <= lres_next;
        rres_reg <= rres_next;
        outl_reg <= outl_next;
        outr_reg <= outr_next;
    end

endmodule

FILE: sv/prv_chk.sv
`timescale 1ns / 1ps
module prv_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input prv_pkg::sample_t left_out,
    input prv_pkg::sample_t right_out
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("output changed while stalled");

    // one pair at a time: busy right after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without processing");

    // a new result only appears after a busy period
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

endmodule

bind plate_reverb_stereo_unit prv_chk u_prv_chk (.*);
